// ===== hdl/hll_pkg.sv =====
// ---------------------------------------------------------------------------
// hll_pkg: shared types of the 1D Euler HLL flux pipeline
// Control word that travels beside the data and the status codes.
// ---------------------------------------------------------------------------
package hll_pkg;

    // control bits carried along each pipeline stage
    typedef struct packed {
        logic valid;
        logic ovf;
        logic order;
    } hll_ctl_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SAT   = 2'd1,
        ST_ORDER = 2'd2
    } hll_status_t;

endpackage

// ===== hdl/hll_div.sv =====
// ---------------------------------------------------------------------------
// hll_div: pipelined signed fixed-point divider
// Computes (num * 2^F) / den with den positive, truncating toward zero,
// one quotient bit per stage, saturating to the signed word range.
// ---------------------------------------------------------------------------
module hll_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hll_pkg::hll_ctl_t  in_ctl,
    input  logic [W-1:0]       num,
    input  logic [W-1:0]       den,
    output hll_pkg::hll_ctl_t  out_ctl,
    output logic [W-1:0]       quo,
    output logic               quo_ov
);

    localparam int L = 2 * W + F;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    hll_pkg::hll_ctl_t ctl_reg [0:W];
    logic [W-1:0]      rem_reg [0:W];
    logic [W-1:0]      low_reg [0:W];
    logic [W-1:0]      quo_reg [0:W];
    logic [W-1:0]      den_reg [0:W];
    logic              neg_reg [0:W];
    logic              big_reg [0:W];

    logic [W-1:0] mag;
    logic [L-1:0] nn;
    logic [L-1:0] dd;

    // magnitude, range check and initial partial remainder
    always_comb
    begin
        mag = num[W-1] ? (~num + 1'b1) : num;
        nn  = L'(mag) << F;
        dd  = L'(den) << W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= nn[2*W-1:W];
        low_reg[0] <= nn[W-1:0];
        quo_reg[0] <= '0;
        den_reg[0] <= den;
        neg_reg[0] <= num[W-1];
        big_reg[0] <= (nn >= dd);
    end

    // one restoring step per stage
    for (genvar s = 0; s < W; s++)
    begin : g_step
        logic [W:0] trial;
        logic       fits;

        always_comb
        begin
            trial = {rem_reg[s], low_reg[s][W-1]};
            fits  = (trial >= {1'b0, den_reg[s]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s+1] <= '0;
            end
            else
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= fits ? W'(trial - {1'b0, den_reg[s]}) : trial[W-1:0];
            low_reg[s+1] <= {low_reg[s][W-2:0], 1'b0};
            quo_reg[s+1] <= {quo_reg[s][W-2:0], fits};
            den_reg[s+1] <= den_reg[s];
            neg_reg[s+1] <= neg_reg[s];
            big_reg[s+1] <= big_reg[s];
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        out_ctl = ctl_reg[W];
        quo_ov  = 1'b0;
        quo     = quo_reg[W];
        if (big_reg[W])
        begin
            quo_ov = 1'b1;
            quo    = neg_reg[W] ? MINV : MAXV;
        end
        else if (!neg_reg[W])
        begin
            if (quo_reg[W] > MAXV)
            begin
                quo_ov = 1'b1;
                quo    = MAXV;
            end
        end
        else
        begin
            if (quo_reg[W] > MINV)
            begin
                quo_ov = 1'b1;
                quo    = MINV;
            end
            else
            begin
                quo = ~quo_reg[W] + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/euler_1d_hll_flux.sv =====
// ---------------------------------------------------------------------------
// euler_1d_hll_flux: HLL flux of the 1D Euler equations at one interface
// Physical fluxes of both sides, HLL combination and a pipelined divide,
// all in saturating signed fixed point.
// ---------------------------------------------------------------------------
//  channel   handshake              word
//  input     start / busy           left_*, right_* state, left/right_speed
//  config    cfg_valid / cfg_ready  cfg_data (inv_gamma_minus_one)
//  result    done (one cycle)       flux_density/momentum/energy, status
//
//  One interface per cycle enters; busy stays low and cfg_ready stays high.
//  The path runs through six arithmetic stages, then the divider that resolves
//  one quotient bit per stage, then the output register.
//  Reset clears all valid bits and loads inv_gamma_minus_one with 2.5.
//  The result is shown for one cycle with done; nothing downstream stalls.
// ---------------------------------------------------------------------------
module euler_1d_hll_flux #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [30:0]                  cfg_data,
    input  logic signed [DATA_WIDTH-1:0] left_density,
    input  logic signed [DATA_WIDTH-1:0] left_velocity,
    input  logic signed [DATA_WIDTH-1:0] left_pressure,
    input  logic signed [DATA_WIDTH-1:0] left_momentum,
    input  logic signed [DATA_WIDTH-1:0] left_energy,
    input  logic signed [DATA_WIDTH-1:0] right_density,
    input  logic signed [DATA_WIDTH-1:0] right_velocity,
    input  logic signed [DATA_WIDTH-1:0] right_pressure,
    input  logic signed [DATA_WIDTH-1:0] right_momentum,
    input  logic signed [DATA_WIDTH-1:0] right_energy,
    input  logic signed [DATA_WIDTH-1:0] left_speed,
    input  logic signed [DATA_WIDTH-1:0] right_speed,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] flux_density,
    output logic signed [DATA_WIDTH-1:0] flux_momentum,
    output logic signed [DATA_WIDTH-1:0] flux_energy,
    output logic [1:0]                   status
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int LAT = W + 8;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [30:0]  GAMMA_RESET = 31'd163840;

    // saturating helpers, result is {overflow, value}
    function automatic logic [W:0] f_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            return {1'b1, s[W] ? MINV : MAXV};
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] f_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
            return {1'b1, s[W] ? MINV : MAXV};
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] f_mul(input logic [W-1:0] a, input logic [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = $signed(a) * $signed(b);
        p = p >>> F;
        if ((&p[2*W-1:W-1]) || !(|p[2*W-1:W-1]))
            return {1'b0, p[W-1:0]};
        return {1'b1, p[2*W-1] ? MINV : MAXV};
    endfunction

    function automatic logic [W:0] f_mulg(input logic [W-1:0] a, input logic [30:0] g);
        logic signed [W+31:0] p;
        p = $signed(a) * $signed({1'b0, g});
        p = p >>> F;
        if ((&p[W+31:W-1]) || !(|p[W+31:W-1]))
            return {1'b0, p[W-1:0]};
        return {1'b1, p[W+31] ? MINV : MAXV};
    endfunction

    logic [30:0] gam_reg;
    hll_pkg::hll_ctl_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    hll_pkg::hll_ctl_t c1_next, c2_next, c3_next, c4_next, c5_next, c6_next;

    // stage 1
    logic [W-1:0] l_uu_reg, r_uu_reg, l_pg_reg, r_pg_reg, l_mu_reg, r_mu_reg;
    logic [W-1:0] den1_reg, dd0_reg, dd1_reg, dd2_reg, s2_reg;
    logic [W-1:0] l_rho_reg, r_rho_reg, l_u1_reg, r_u1_reg, l_p1_reg, r_p1_reg;
    logic [W-1:0] l_m1_reg, r_m1_reg, sl1_reg, sr1_reg;
    logic [W:0]   l_uu_t, r_uu_t, l_pg_t, r_pg_t, l_mu_t, r_mu_t;
    logic [W:0]   den_t, dd0_t, dd1_t, dd2_t, s2_t;
    // stage 2
    logic [W-1:0] l_uur_reg, r_uur_reg, l_fm_reg, r_fm_reg, s2d0_reg, s2d1_reg, s2d2_reg;
    logic [W-1:0] l_pg2_reg, r_pg2_reg, l_p2_reg, r_p2_reg, l_u2_reg, r_u2_reg;
    logic [W-1:0] l_m2_reg, r_m2_reg, sl2_reg, sr2_reg, den2_reg;
    logic [W:0]   l_uur_t, r_uur_t, l_fm_t, r_fm_t, s2d0_t, s2d1_t, s2d2_t;
    // stage 3
    logic [W-1:0] l_h_reg, r_h_reg, a0_reg, b0_reg, a1_reg, b1_reg;
    logic [W-1:0] l_u3_reg, r_u3_reg, sl3_reg, sr3_reg, den3_reg;
    logic [W-1:0] s2d0_3_reg, s2d1_3_reg, s2d2_3_reg;
    logic [W:0]   l_h1_t, r_h1_t, l_h_t, r_h_t, a0_t, b0_t, a1_t, b1_t;
    // stage 4
    logic [W-1:0] l_fe_reg, r_fe_reg, num0_4_reg, num1_4_reg;
    logic [W-1:0] sl4_reg, sr4_reg, den4_reg, s2d2_4_reg;
    logic [W:0]   l_fe_t, r_fe_t, n0a_t, n0_t, n1a_t, n1_t;
    // stage 5
    logic [W-1:0] a2_reg, b2_reg, num0_5_reg, num1_5_reg, den5_reg, s2d2_5_reg;
    logic [W:0]   a2_t, b2_t;
    // stage 6
    logic [W-1:0] num0_6_reg, num1_6_reg, num2_6_reg, den6_reg;
    logic [W:0]   n2a_t, n2_t;

    hll_pkg::hll_ctl_t dctl0, dctl1, dctl2;
    logic [W-1:0]      q0, q1, q2;
    logic              qov0, qov1, qov2;

    logic              done_reg;
    logic [W-1:0]      fd_reg, fm_reg, fe_reg;
    logic [1:0]        st_reg;
    logic [1:0]        st_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gam_reg <= GAMMA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gam_reg <= cfg_data;
        end
    end

    // stage 1: squares, pressure scaling, speed products and differences
    always_comb
    begin
        l_uu_t = f_mul(left_velocity, left_velocity);
        r_uu_t = f_mul(right_velocity, right_velocity);
        l_pg_t = f_mulg(left_pressure, gam_reg);
        r_pg_t = f_mulg(right_pressure, gam_reg);
        l_mu_t = f_mul(left_momentum, left_velocity);
        r_mu_t = f_mul(right_momentum, right_velocity);
        den_t  = f_sub(right_speed, left_speed);
        dd0_t  = f_sub(right_density, left_density);
        dd1_t  = f_sub(right_momentum, left_momentum);
        dd2_t  = f_sub(right_energy, left_energy);
        s2_t   = f_mul(left_speed, right_speed);
        c1_next.valid = start && !busy;
        c1_next.order = !(right_speed > left_speed);
        c1_next.ovf   = l_uu_t[W] | r_uu_t[W] | l_pg_t[W] | r_pg_t[W] | l_mu_t[W]
                      | r_mu_t[W] | den_t[W] | dd0_t[W] | dd1_t[W] | dd2_t[W] | s2_t[W];
    end

    // stage 2: kinetic product, momentum flux, s2 times jumps
    always_comb
    begin
        l_uur_t = f_mul(l_uu_reg, l_rho_reg);
        r_uur_t = f_mul(r_uu_reg, r_rho_reg);
        l_fm_t  = f_add(l_mu_reg, l_p1_reg);
        r_fm_t  = f_add(r_mu_reg, r_p1_reg);
        s2d0_t  = f_mul(s2_reg, dd0_reg);
        s2d1_t  = f_mul(s2_reg, dd1_reg);
        s2d2_t  = f_mul(s2_reg, dd2_reg);
        c2_next = c1_reg;
        c2_next.ovf = c1_reg.ovf | l_uur_t[W] | r_uur_t[W] | l_fm_t[W] | r_fm_t[W]
                    | s2d0_t[W] | s2d1_t[W] | s2d2_t[W];
    end

    // stage 3: enthalpy term and speed-weighted fluxes
    always_comb
    begin
        l_h1_t = f_add(l_pg2_reg, {l_uur_reg[W-1], l_uur_reg[W-1:1]});
        r_h1_t = f_add(r_pg2_reg, {r_uur_reg[W-1], r_uur_reg[W-1:1]});
        l_h_t  = f_add(l_h1_t[W-1:0], l_p2_reg);
        r_h_t  = f_add(r_h1_t[W-1:0], r_p2_reg);
        a0_t   = f_mul(sr2_reg, l_m2_reg);
        b0_t   = f_mul(sl2_reg, r_m2_reg);
        a1_t   = f_mul(sr2_reg, l_fm_reg);
        b1_t   = f_mul(sl2_reg, r_fm_reg);
        c3_next = c2_reg;
        c3_next.ovf = c2_reg.ovf | l_h1_t[W] | r_h1_t[W] | l_h_t[W] | r_h_t[W]
                    | a0_t[W] | b0_t[W] | a1_t[W] | b1_t[W];
    end

    // stage 4: energy flux and first two numerators
    always_comb
    begin
        l_fe_t = f_mul(l_h_reg, l_u3_reg);
        r_fe_t = f_mul(r_h_reg, r_u3_reg);
        n0a_t  = f_sub(a0_reg, b0_reg);
        n0_t   = f_add(n0a_t[W-1:0], s2d0_3_reg);
        n1a_t  = f_sub(a1_reg, b1_reg);
        n1_t   = f_add(n1a_t[W-1:0], s2d1_3_reg);
        c4_next = c3_reg;
        c4_next.ovf = c3_reg.ovf | l_fe_t[W] | r_fe_t[W] | n0a_t[W] | n0_t[W]
                    | n1a_t[W] | n1_t[W];
    end

    // stage 5: speed-weighted energy fluxes
    always_comb
    begin
        a2_t = f_mul(sr4_reg, l_fe_reg);
        b2_t = f_mul(sl4_reg, r_fe_reg);
        c5_next = c4_reg;
        c5_next.ovf = c4_reg.ovf | a2_t[W] | b2_t[W];
    end

    // stage 6: energy numerator
    always_comb
    begin
        n2a_t = f_sub(a2_reg, b2_reg);
        n2_t  = f_add(n2a_t[W-1:0], s2d2_5_reg);
        c6_next = c5_reg;
        c6_next.ovf = c5_reg.ovf | n2a_t[W] | n2_t[W];
    end

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else
        begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
            c4_reg <= c4_next;
            c5_reg <= c5_next;
            c6_reg <= c6_next;
        end
    end

    // data pipeline
    always_ff @(posedge clk)
    begin
        l_uu_reg  <= l_uu_t[W-1:0];
        r_uu_reg  <= r_uu_t[W-1:0];
        l_pg_reg  <= l_pg_t[W-1:0];
        r_pg_reg  <= r_pg_t[W-1:0];
        l_mu_reg  <= l_mu_t[W-1:0];
        r_mu_reg  <= r_mu_t[W-1:0];
        den1_reg  <= den_t[W-1:0];
        dd0_reg   <= dd0_t[W-1:0];
        dd1_reg   <= dd1_t[W-1:0];
        dd2_reg   <= dd2_t[W-1:0];
        s2_reg    <= s2_t[W-1:0];
        l_rho_reg <= left_density;
        r_rho_reg <= right_density;
        l_u1_reg  <= left_velocity;
        r_u1_reg  <= right_velocity;
        l_p1_reg  <= left_pressure;
        r_p1_reg  <= right_pressure;
        l_m1_reg  <= left_momentum;
        r_m1_reg  <= right_momentum;
        sl1_reg   <= left_speed;
        sr1_reg   <= right_speed;

        l_uur_reg <= l_uur_t[W-1:0];
        r_uur_reg <= r_uur_t[W-1:0];
        l_fm_reg  <= l_fm_t[W-1:0];
        r_fm_reg  <= r_fm_t[W-1:0];
        s2d0_reg  <= s2d0_t[W-1:0];
        s2d1_reg  <= s2d1_t[W-1:0];
        s2d2_reg  <= s2d2_t[W-1:0];
        l_pg2_reg <= l_pg_reg;
        r_pg2_reg <= r_pg_reg;
        l_p2_reg  <= l_p1_reg;
        r_p2_reg  <= r_p1_reg;
        l_u2_reg  <= l_u1_reg;
        r_u2_reg  <= r_u1_reg;
        l_m2_reg  <= l_m1_reg;
        r_m2_reg  <= r_m1_reg;
        sl2_reg   <= sl1_reg;
        sr2_reg   <= sr1_reg;
        den2_reg  <= den1_reg;

        l_h_reg    <= l_h_t[W-1:0];
        r_h_reg    <= r_h_t[W-1:0];
        a0_reg     <= a0_t[W-1:0];
        b0_reg     <= b0_t[W-1:0];
        a1_reg     <= a1_t[W-1:0];
        b1_reg     <= b1_t[W-1:0];
        l_u3_reg   <= l_u2_reg;
        r_u3_reg   <= r_u2_reg;
        sl3_reg    <= sl2_reg;
        sr3_reg    <= sr2_reg;
        den3_reg   <= den2_reg;
        s2d0_3_reg <= s2d0_reg;
        s2d1_3_reg <= s2d1_reg;
        s2d2_3_reg <= s2d2_reg;

        l_fe_reg   <= l_fe_t[W-1:0];
        r_fe_reg   <= r_fe_t[W-1:0];
        num0_4_reg <= n0_t[W-1:0];
        num1_4_reg <= n1_t[W-1:0];
        sl4_reg    <= sl3_reg;
        sr4_reg    <= sr3_reg;
        den4_reg   <= den3_reg;
        s2d2_4_reg <= s2d2_3_reg;

        a2_reg     <= a2_t[W-1:0];
        b2_reg     <= b2_t[W-1:0];
        num0_5_reg <= num0_4_reg;
        num1_5_reg <= num1_4_reg;
        den5_reg   <= den4_reg;
        s2d2_5_reg <= s2d2_4_reg;

        num0_6_reg <= num0_5_reg;
        num1_6_reg <= num1_5_reg;
        num2_6_reg <= n2_t[W-1:0];
        den6_reg   <= den5_reg;
    end

    // one divider per flux component
    hll_div #(.W(W), .F(F)) u_div_d (
        .clk(clk), .rst_n(rst_n), .in_ctl(c6_reg), .num(num0_6_reg), .den(den6_reg),
        .out_ctl(dctl0), .quo(q0), .quo_ov(qov0)
    );

    hll_div #(.W(W), .F(F)) u_div_m (
        .clk(clk), .rst_n(rst_n), .in_ctl(c6_reg), .num(num1_6_reg), .den(den6_reg),
        .out_ctl(dctl1), .quo(q1), .quo_ov(qov1)
    );

    hll_div #(.W(W), .F(F)) u_div_e (
        .clk(clk), .rst_n(rst_n), .in_ctl(c6_reg), .num(num2_6_reg), .den(den6_reg),
        .out_ctl(dctl2), .quo(q2), .quo_ov(qov2)
    );

    // status of the finished word
    always_comb
    begin
        if (dctl0.order)
            st_next = hll_pkg::ST_ORDER;
        else if (dctl0.ovf || dctl1.ovf || dctl2.ovf || qov0 || qov1 || qov2)
            st_next = hll_pkg::ST_SAT;
        else
            st_next = hll_pkg::ST_OK;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dctl0.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        fd_reg <= dctl0.order ? '0 : q0;
        fm_reg <= dctl0.order ? '0 : q1;
        fe_reg <= dctl0.order ? '0 : q2;
        st_reg <= st_next;
    end

    assign done          = done_reg;
    assign flux_density  = fd_reg;
    assign flux_momentum = fm_reg;
    assign flux_energy   = fe_reg;
    assign status        = st_reg;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result did not appear after the pipeline latency");

    a_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == hll_pkg::ST_ORDER) |->
        (flux_density == '0 && flux_momentum == '0 && flux_energy == '0))
        else $error("speed order error with nonzero flux");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == hll_pkg::ST_OK || status == hll_pkg::ST_SAT ||
                  status == hll_pkg::ST_ORDER))
        else $error("undefined status code");

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for the 1D Euler HLL interface flux
// Directed rows, then constrained-by-hand random interfaces, are streamed at
// one word per cycle under several idle patterns and gamma settings. A
// fixed-point predictor (or a fixed row's given result) gives each flux and
// the checker compares every done word with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int  DW        = 32;
    localparam int  FB        = 16;
    localparam longint SMAX   = 64'sd2147483647;
    localparam longint SMIN   = -64'sd2147483648;
    localparam int  LATENCY   = DW + 8;
    localparam int  STALL_MAX = 20000;
    localparam int  N_RANDOM  = 500;
    localparam logic [30:0] GAMMA_RESET = 31'd163840;
    localparam logic [30:0] GAMMA_MAX   = 31'h7fffffff;

    // field positions in one interface word
    localparam int L_RHO = 0, L_U = 1, L_P = 2, L_M = 3, L_E = 4;
    localparam int R_RHO = 5, R_U = 6, R_P = 7, R_M = 8, R_E = 9;
    localparam int S_L = 10, S_R = 11, N_FIELDS = 12;

    typedef logic signed [DW-1:0] word_t;
    typedef word_t iface_t [N_FIELDS];

    typedef struct {
        word_t                fd;
        word_t                fm;
        word_t                fe;
        hll_pkg::hll_status_t st;
    } flux_t;

    typedef struct {
        iface_t in;
        bit     fixed;
        flux_t  res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic cfg_valid = 1'b0;
    logic [30:0] cfg_data = '0;
    logic busy, cfg_ready, done;
    word_t in_w [N_FIELDS] = '{default: '0};
    word_t flux_density, flux_momentum, flux_energy;
    logic [1:0] status;

    flux_t  flux_q[$];
    row_t   rows[$];
    logic [30:0] gamma_q16 = GAMMA_RESET;
    bit     sat_hit;
    int     n_err = 0;
    int     n_done = 0;
    int     n_sent = 0;
    int     n_order = 0;
    int     n_sat = 0;
    int     quiet = 0;

    always #1 clk = ~clk;

    euler_1d_hll_flux #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .left_density(in_w[L_RHO]), .left_velocity(in_w[L_U]),
        .left_pressure(in_w[L_P]), .left_momentum(in_w[L_M]),
        .left_energy(in_w[L_E]), .right_density(in_w[R_RHO]),
        .right_velocity(in_w[R_U]), .right_pressure(in_w[R_P]),
        .right_momentum(in_w[R_M]), .right_energy(in_w[R_E]),
        .left_speed(in_w[S_L]), .right_speed(in_w[S_R]),
        .done(done), .flux_density(flux_density), .flux_momentum(flux_momentum),
        .flux_energy(flux_energy), .status(status)
    );

    // saturating fixed-point helpers
    function automatic longint clamp(longint v);
        if (v > SMAX) begin sat_hit = 1; return SMAX; end
        if (v < SMIN) begin sat_hit = 1; return SMIN; end
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clamp((a * b) >>> FB);
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clamp(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return clamp(a - b);
    endfunction

    // physical flux of one side: mass, momentum, energy
    function automatic void side_flux(longint rho, longint u, longint p, longint m,
                                      output longint f [3]);
        longint kin, h;
        kin  = qmul(qmul(u, u), rho) >>> 1;
        h    = qadd(qadd(qmul(p, longint'(gamma_q16)), kin), p);
        f[0] = m;
        f[1] = qadd(qmul(m, u), p);
        f[2] = qmul(h, u);
    endfunction

    function automatic flux_t hll_flux(iface_t w);
        flux_t  r;
        longint fl [3], fr [3], ul [3], ur [3], q [3];
        longint sl, sr, den, s2, num;
        sl = w[S_L];
        sr = w[S_R];
        r.fd = '0; r.fm = '0; r.fe = '0;
        if (sr <= sl) begin
            r.st = hll_pkg::ST_ORDER;
            return r;
        end
        sat_hit = 0;
        side_flux(w[L_RHO], w[L_U], w[L_P], w[L_M], fl);
        side_flux(w[R_RHO], w[R_U], w[R_P], w[R_M], fr);
        ul = '{longint'(w[L_RHO]), longint'(w[L_M]), longint'(w[L_E])};
        ur = '{longint'(w[R_RHO]), longint'(w[R_M]), longint'(w[R_E])};
        den = qsub(sr, sl);
        s2  = qmul(sl, sr);
        for (int i = 0; i < 3; i++) begin
            num  = qsub(qmul(sr, fl[i]), qmul(sl, fr[i]));
            num  = qadd(num, qmul(s2, qsub(ur[i], ul[i])));
            q[i] = clamp((num <<< FB) / den);
        end
        r.fd = q[0]; r.fm = q[1]; r.fe = q[2];
        r.st = sat_hit ? hll_pkg::ST_SAT : hll_pkg::ST_OK;
        return r;
    endfunction

    // result checker
    always @(posedge clk) begin
        flux_t e;
        if (rst_n && done) begin
            n_done++;
            if (flux_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected done word %h %h %h st=%0d",
                             flux_density, flux_momentum, flux_energy, status);
            end else begin
                e = flux_q.pop_front();
                if (e.fd !== flux_density || e.fm !== flux_momentum ||
                    e.fe !== flux_energy || e.st !== status) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: flux exp %h %h %h st=%0d got %h %h %h st=%0d",
                                 e.fd, e.fm, e.fe, e.st, flux_density, flux_momentum,
                                 flux_energy, status);
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_MAX) begin
            $display("watchdog: no progress for %0d cycles", STALL_MAX);
            $display("Regression FAIL");
            $finish;
        end
    end

    // one interface word, with an optional idle gap ahead of it
    task automatic send_iface(iface_t w, bit fixed, flux_t res, int idle_pct);
        flux_t e;
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        for (int i = 0; i < N_FIELDS; i++)
            in_w[i] <= w[i];
        start <= 1'b1;
        do @(posedge clk); while (busy);
        e = fixed ? res : hll_flux(w);
        if (e.st == hll_pkg::ST_ORDER) n_order++;
        if (e.st == hll_pkg::ST_SAT) n_sat++;
        flux_q.push_back(e);
        n_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (flux_q.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_gamma(logic [30:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gamma_q16 = v;
    endtask

    function automatic word_t fx(int whole_q16);
        return word_t'(whole_q16);
    endfunction

    task automatic add_row(iface_t w, bit fixed, word_t fd, word_t fm, word_t fe,
                           hll_pkg::hll_status_t st);
        row_t r;
        r.in = w; r.fixed = fixed;
        r.res = '{fd, fm, fe, st};
        rows.push_back(r);
    endtask

    function automatic word_t rnd_full();
        return word_t'($urandom);
    endfunction

    function automatic word_t hll_mom(word_t rho, word_t u);
        return word_t'((longint'(rho) * longint'(u)) >>> FB);
    endfunction

    // physically plausible interface, or noise, or reversed speeds
    function automatic iface_t rnd_iface();
        iface_t w;
        int kind;
        kind = $urandom_range(99, 0);
        for (int i = 0; i < N_FIELDS; i++)
            w[i] = rnd_full();
        if (kind < 75) begin
            w[L_RHO] = $urandom_range(32'h0004_0000, 32'h0000_1000);
            w[R_RHO] = $urandom_range(32'h0004_0000, 32'h0000_1000);
            w[L_P]   = $urandom_range(32'h0004_0000, 32'h0000_1000);
            w[R_P]   = $urandom_range(32'h0004_0000, 32'h0000_1000);
            w[L_U]   = $signed($urandom_range(32'h0006_0000, 0)) - 32'sh0003_0000;
            w[R_U]   = $signed($urandom_range(32'h0006_0000, 0)) - 32'sh0003_0000;
            w[L_M]   = hll_mom(w[L_RHO], w[L_U]);
            w[R_M]   = hll_mom(w[R_RHO], w[R_U]);
            w[L_E]   = $urandom_range(32'h000a_0000, 32'h0000_1000);
            w[R_E]   = $urandom_range(32'h000a_0000, 32'h0000_1000);
            w[S_L]   = $signed($urandom_range(32'h0008_0000, 0)) - 32'sh0006_0000;
            w[S_R]   = w[S_L] + $signed($urandom_range(32'h0008_0000, 1));
        end else if (kind < 88) begin
            w[S_R] = w[S_L] - $signed($urandom_range(3, 0));
            if (w[S_R] > w[S_L]) w[S_R] = w[S_L];
        end
        return w;
    endfunction

    initial begin
        iface_t w;
        int idle_pct [4];
        logic [30:0] gammas [4];

        idle_pct = '{0, 50, 0, 34};
        for (int i = 0; i < N_FIELDS; i++)
            w[i] = '0;

        // reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        w[S_L] = fx(-32'sh10000); w[S_R] = fx(32'sh10000);
        add_row(w, 1, '0, '0, '0, hll_pkg::ST_OK);
        w[S_R] = w[S_L];
        add_row(w, 1, '0, '0, '0, hll_pkg::ST_ORDER);
        w[S_L] = SMAX[31:0]; w[S_R] = SMIN[31:0];
        add_row(w, 1, '0, '0, '0, hll_pkg::ST_ORDER);
        for (int i = 0; i < S_L; i++) w[i] = SMAX[31:0];
        w[S_L] = SMIN[31:0]; w[S_R] = SMAX[31:0];
        add_row(w, 0, '0, '0, '0, hll_pkg::ST_OK);
        for (int i = 0; i < S_L; i++) w[i] = SMIN[31:0];
        add_row(w, 0, '0, '0, '0, hll_pkg::ST_OK);
        for (int i = 0; i < N_FIELDS; i++) w[i] = '1;
        w[S_R] = '0;
        add_row(w, 0, '0, '0, '0, hll_pkg::ST_OK);
        // sod-like shock tube pair
        w = '{32'sh10000, 0, 32'sh10000, 0, 32'sh28000,
              32'sh2000, 0, 32'sh1999, 0, 32'sh3fff,
              -32'sh12ed9, 32'sh12ed9};
        add_row(w, 0, '0, '0, '0, hll_pkg::ST_OK);
        w = '{32'sh10000, 32'sh8000, 32'sh10000, 32'sh8000, 32'sh2a000,
              32'sh10000, -32'sh8000, 32'sh10000, -32'sh8000, 32'sh2a000,
              -32'sh20000, 32'sh20000};
        add_row(w, 0, '0, '0, '0, hll_pkg::ST_OK);
        // smallest positive span between the speeds
        w[S_L] = 32'sh1; w[S_R] = 32'sh2;
        add_row(w, 0, '0, '0, '0, hll_pkg::ST_OK);
        w[S_L] = -32'sh2; w[S_R] = -32'sh1;
        add_row(w, 0, '0, '0, '0, hll_pkg::ST_OK);
        for (int i = 0; i < 6; i++)
            add_row(rnd_iface(), 0, '0, '0, '0, hll_pkg::ST_OK);

        foreach (rows[i])
            send_iface(rows[i].in, rows[i].fixed, rows[i].res, 0);

        // random phases under different gamma settings
        gammas = '{31'd0, GAMMA_MAX, 31'd98304, 31'($urandom)};
        for (int ph = 0; ph < 4; ph++) begin
            write_gamma(ph == 0 ? GAMMA_RESET : gammas[ph]);
            for (int n = 0; n < N_RANDOM; n++)
                send_iface(rnd_iface(), 0, '{'0, '0, '0, hll_pkg::ST_OK}, idle_pct[ph]);
        end
        write_gamma(gammas[0]);
        for (int n = 0; n < 40; n++)
            send_iface(rnd_iface(), 0, '{'0, '0, '0, hll_pkg::ST_OK}, 0);
        drain();

        $display("covered %0d interfaces, %0d flux words: %0d saturated, %0d out of order",
                 n_sent, n_done, n_sat, n_order);
        $display("gamma settings include zero, full scale and reset; idle 0/50/34 pct");
        if (n_err == 0 && flux_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/hll_pkg.sv
hdl/hll_div.sv
hdl/euler_1d_hll_flux.sv
dv/tb.sv
